/* rtl/core/chd_pkg.sv */
// ----------------------------------------------------------------------------
// chd_pkg
// Shared widths, constants, the CORDIC vector type and the arctangent table
// for the compass heading pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package chd_pkg;

  // Sample and angle formats
  localparam int unsigned MAG_W      = 17;  // magnetometer field width
  localparam int unsigned SCALE_BITS = 14;  // inputs are scaled by 2^14
  localparam int unsigned XY_W       = 34;  // room for the CORDIC gain
  localparam int unsigned Z_W        = 26;  // angle, degrees Q.16
  localparam int unsigned H_W        = 27;  // heading sum, degrees Q.16
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned DECL_W     = 9;
  localparam int unsigned HEAD_W     = 9;
  localparam int unsigned ATAN_LEN   = 24;  // entries in the arctangent table
  localparam int unsigned ATAN_W     = 23;

  // Angle constants in degrees Q.16
  localparam logic signed [Z_W-1:0] Z_90   = 26'sd5898240;   // 90 degrees
  localparam logic signed [Z_W-1:0] Z_180  = 26'sd11796480;  // 180 degrees
  localparam logic signed [H_W-1:0] H_FULL = 27'sd23592960;  // 360 degrees

  // Declination saturation limit in whole degrees
  localparam logic signed [DECL_W-1:0] DECL_MAX = 9'sd180;

  // Vector carried from one CORDIC stage to the next
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   byp;  // angle already exact, skip rotations
  } chd_vec_t;

  // atan(2^-i) in degrees Q.16, rounded to nearest
  function automatic logic [ATAN_W-1:0] chd_atan(input logic [4:0] idx);
    logic [ATAN_W-1:0] r;
    case (idx)
      5'd0:    r = 23'd2949120;
      5'd1:    r = 23'd1740967;
      5'd2:    r = 23'd919879;
      5'd3:    r = 23'd466945;
      5'd4:    r = 23'd234379;
      5'd5:    r = 23'd117304;
      5'd6:    r = 23'd58666;
      5'd7:    r = 23'd29335;
      5'd8:    r = 23'd14668;
      5'd9:    r = 23'd7334;
      5'd10:   r = 23'd3667;
      5'd11:   r = 23'd1833;
      5'd12:   r = 23'd917;
      5'd13:   r = 23'd458;
      5'd14:   r = 23'd229;
      5'd15:   r = 23'd115;
      5'd16:   r = 23'd57;
      5'd17:   r = 23'd29;
      5'd18:   r = 23'd14;
      5'd19:   r = 23'd7;
      5'd20:   r = 23'd4;
      5'd21:   r = 23'd2;
      5'd22:   r = 23'd1;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/chd_cordic_stage.sv */
// ----------------------------------------------------------------------------
// chd_cordic_stage
// One registered vectoring micro-rotation of the CORDIC pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_cordic_stage
  import chd_pkg::*;
#(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire logic     valid_i,
  input  wire chd_vec_t data_i,
  output logic          valid_o,
  output chd_vec_t      data_o
);

  localparam logic [ATAN_W-1:0] ATAN_STEP = chd_atan(5'(SHIFT));

  logic                   valid_q;
  chd_vec_t               data_q;
  chd_vec_t               data_d;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic                   y_pos;

  // Rotate toward the x axis; exact angles pass untouched
  always_comb begin
    xs     = data_i.x >>> SHIFT;
    ys     = data_i.y >>> SHIFT;
    y_pos  = !data_i.y[XY_W-1] && (data_i.y != '0);
    data_d = data_i;
    if (!data_i.byp) begin
      if (y_pos) begin
        data_d.x = data_i.x + ys;
        data_d.y = data_i.y - xs;
        data_d.z = data_i.z + $signed({3'b000, ATAN_STEP});
      end else begin
        data_d.x = data_i.x - ys;
        data_d.y = data_i.y + xs;
        data_d.z = data_i.z - $signed({3'b000, ATAN_STEP});
      end
    end
  end

  // Advance when the next stage can take the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* rtl/core/compass_heading_from_magnetometer_top.sv */
// ----------------------------------------------------------------------------
// compass_heading_from_magnetometer_top
// Whole-degree compass heading from one X/Y magnetometer sample.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while in_stall_o is low and returns one
// heading per sample, in order. The pipeline has one input stage for scaling
// and the +-90 degree pre-rotation, one stage per CORDIC micro-rotation, and
// two stages that add the declination and wrap into 0..360. Each stage holds
// its request while the next one cannot move, so bubbles collapse and a
// stalled output still lets new samples fill the pipeline. The declination
// register is read, saturated to -180..180, when a sample reaches the heading
// stage; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module compass_heading_from_magnetometer_top
  import chd_pkg::*;
#(
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic signed [DECL_W-1:0] cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [MAG_W-1:0]  mag_x_i,
  input  wire logic signed [MAG_W-1:0]  mag_y_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [HEAD_W-1:0]             heading_deg_o
);

  localparam int unsigned NUM_ITER =
      (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;
  localparam int unsigned NUM_ST   = NUM_ITER + 3;

  logic [NUM_ST-1:0] vld;
  logic [NUM_ST:0]   adv;
  chd_vec_t          vec [NUM_ITER+1];

  // Declination register
  logic signed [DECL_W-1:0] decl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_q <= '0;
    end else if (cfg_we_i) begin
      decl_q <= cfg_wdata_i;
    end
  end

  // Per-stage advance: a stage moves if it is empty or the next one moves
  assign adv[NUM_ST] = !out_stall_i;
  for (genvar k = 0; k < NUM_ST; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end

  assign in_stall_o = !adv[0];

  // Input stage: scale, detect axis points, pre-rotate into right half plane
  logic                   pre_vld_q;
  chd_vec_t               pre_q;
  chd_vec_t               pre_d;
  logic signed [XY_W-1:0] x_sc;
  logic signed [XY_W-1:0] y_sc;

  always_comb begin
    x_sc  = {{(XY_W-MAG_W-SCALE_BITS){mag_x_i[MAG_W-1]}}, mag_x_i, {SCALE_BITS{1'b0}}};
    y_sc  = {{(XY_W-MAG_W-SCALE_BITS){mag_y_i[MAG_W-1]}}, mag_y_i, {SCALE_BITS{1'b0}}};
    pre_d.x   = x_sc;
    pre_d.y   = y_sc;
    pre_d.z   = '0;
    pre_d.byp = 1'b0;
    if (mag_y_i == '0) begin
      pre_d.byp = 1'b1;
      pre_d.z   = mag_x_i[MAG_W-1] ? Z_180 : '0;
    end else if (mag_x_i == '0) begin
      pre_d.byp = 1'b1;
      pre_d.z   = mag_y_i[MAG_W-1] ? -Z_90 : Z_90;
    end else if (mag_x_i[MAG_W-1]) begin
      if (!mag_y_i[MAG_W-1]) begin
        pre_d.x = y_sc;
        pre_d.y = -x_sc;
        pre_d.z = Z_90;
      end else begin
        pre_d.x = -y_sc;
        pre_d.y = x_sc;
        pre_d.z = -Z_90;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
    end else if (adv[0]) begin
      pre_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      pre_q <= pre_d;
    end
  end

  assign vld[0] = pre_vld_q;
  assign vec[0] = pre_q;

  // CORDIC micro-rotations, one per stage
  for (genvar i = 0; i < NUM_ITER; i++) begin : g_iter
    chd_cordic_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv[i+1]),
      .valid_i (vld[i]),
      .data_i  (vec[i]),
      .valid_o (vld[i+1]),
      .data_o  (vec[i+1])
    );
  end

  // Heading stage one: add saturated declination, wrap negative sums
  logic signed [DECL_W-1:0] decl_sat;
  logic signed [H_W-1:0]    h_sum;
  logic signed [H_W-1:0]    h1_d;
  logic signed [H_W-1:0]    h1_q;
  logic                     f1_vld_q;

  always_comb begin
    if (decl_q > DECL_MAX) begin
      decl_sat = DECL_MAX;
    end else if (decl_q < -DECL_MAX) begin
      decl_sat = -DECL_MAX;
    end else begin
      decl_sat = decl_q;
    end
    h_sum = {vec[NUM_ITER].z[Z_W-1], vec[NUM_ITER].z}
          + {{(H_W-DECL_W-FRAC_BITS){decl_sat[DECL_W-1]}}, decl_sat, {FRAC_BITS{1'b0}}};
    h1_d  = h_sum[H_W-1] ? (h_sum + H_FULL) : h_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (adv[NUM_ITER+1]) begin
      f1_vld_q <= vld[NUM_ITER];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NUM_ITER+1]) begin
      h1_q <= h1_d;
    end
  end

  assign vld[NUM_ITER+1] = f1_vld_q;

  // Heading stage two: wrap sums above 360, clamp, truncate to degrees
  logic signed [H_W-1:0] h2;
  logic signed [H_W-1:0] h3;
  logic [HEAD_W-1:0]     head_d;
  logic [HEAD_W-1:0]     head_q;
  logic                  out_vld_q;

  always_comb begin
    h2 = (h1_q > H_FULL) ? (h1_q - H_FULL) : h1_q;
    if (h2[H_W-1]) begin
      h3 = '0;
    end else if (h2 > H_FULL) begin
      h3 = H_FULL;
    end else begin
      h3 = h2;
    end
    head_d = h3[FRAC_BITS+HEAD_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv[NUM_ITER+2]) begin
      out_vld_q <= vld[NUM_ITER+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NUM_ITER+2]) begin
      head_q <= head_d;
    end
  end

  assign vld[NUM_ITER+2] = out_vld_q;
  assign out_valid_o     = out_vld_q;
  assign heading_deg_o   = head_q;

endmodule

`default_nettype wire

/* rtl/core/chd_checker.sv */
// ----------------------------------------------------------------------------
// chd_checker
// Port-level checks for the compass heading block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_checker
  import chd_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [HEAD_W-1:0] heading_deg_o
);

  // Input backs up only when a finished request waits at a stalled output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output request");

  // Heading stays within one turn
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_deg_o <= 9'd360))
    else $error("heading above 360 degrees");

  // Hold a stalled output request
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled output request dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(heading_deg_o))
    else $error("stalled output payload changed");

endmodule

bind compass_heading_from_magnetometer_top chd_checker u_chd_checker (.*);

`default_nettype wire
